// ===== hw/rtl/afs_pkg.sv =====
// Package for the animation frame sequencer: widths, operation and mode codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package afs_pkg;

	// Table and field sizes
	localparam int MOTIONS    = 16;
	localparam int SEL_W      = 4;
	localparam int MAX_FRAMES = 1024;
	localparam int FRAME_W    = 11;
	localparam int MODE_W     = 4;
	localparam int OP_W       = 3;
	localparam int FREQ_W     = 12;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int MCNT_W     = 4;

	// Remainder unit runs one bit of the dividend per cycle
	localparam logic [MCNT_W-1:0] MOD_LAST = MCNT_W'(FRAME_W - 1);

	localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_FRAMES);
	localparam logic signed [FREQ_W-1:0] FREQ_KEEP = -12'sd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_COUNT = 1'd1;

	// Play modes
	localparam logic [MODE_W-1:0] MODE_STOP        = 4'd0;
	localparam logic [MODE_W-1:0] MODE_ONCE        = 4'd1;
	localparam logic [MODE_W-1:0] MODE_LOOP        = 4'd2;
	localparam logic [MODE_W-1:0] MODE_REV_ONCE    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_REV_LOOP    = 4'd4;
	localparam logic [MODE_W-1:0] MODE_SL_ONCE     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_SL_LOOP     = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SL_REV_ONCE = 4'd7;
	localparam logic [MODE_W-1:0] MODE_SL_REV_LOOP = 4'd8;
	localparam logic [MODE_W-1:0] MODE_SEAMLESS_OFS = 4'd4;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_CHANGE = 3'd1,
		OP_PLAY   = 3'd2,
		OP_STOP   = 3'd3,
		OP_LOAD   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_A,
		S_EXEC,
		S_MOD,
		S_RD_B,
		S_FIX,
		S_RD_C,
		S_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic rd_first;
		logic exec;
		logic mod_step;
		logic fix_last;
		logic fin_load;
	} cmd_t;

	typedef struct packed {
		logic mod_go;
		logic fix_go;
		logic mod_last;
	} sts_t;

endpackage

// ===== hw/rtl/afs_if.sv =====
// Channel interfaces of the animation frame sequencer: command words in,
// result words out and configuration writes. Depends on afs_pkg.
`timescale 1ns / 1ps

interface afs_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [afs_pkg::OP_W-1:0]             op;
	logic [afs_pkg::SEL_W-1:0]            motion_sel;
	logic [afs_pkg::MODE_W-1:0]           mode_req;
	logic signed [afs_pkg::FREQ_W-1:0]    frame_req;
	logic [afs_pkg::FRAME_W-1:0]          length_in;

	modport source (output valid, op, motion_sel, mode_req, frame_req, length_in,
		input ready);
	modport sink (input valid, op, motion_sel, mode_req, frame_req, length_in,
		output ready);
endinterface

interface afs_result_if;
	logic                             valid;
	logic                             ready;
	logic [afs_pkg::FRAME_W-1:0]      frame_now;
	logic [afs_pkg::SEL_W-1:0]        motion_now;
	logic [afs_pkg::MODE_W-1:0]       mode_now;
	logic                             accepted;
	logic                             playing;

	modport source (output valid, frame_now, motion_now, mode_now, accepted, playing,
		input ready);
	modport sink (input valid, frame_now, motion_now, mode_now, accepted, playing,
		output ready);
endinterface

interface afs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [afs_pkg::CFG_IDX_W-1:0]       index;
	logic [afs_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/afs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module afs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/afs_ctrl.sv =====
// Controller of the animation frame sequencer: state machine that steps each
// command word through table reads, update, remainder and result. Depends on afs_pkg.
`timescale 1ns / 1ps

module afs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  afs_pkg::sts_t sts,
	output afs_pkg::cmd_t cmd
);

	afs_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic fin_ok;

	assign fin_ok    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == afs_pkg::S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			afs_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = afs_pkg::S_RD_A;
				end
			end
			afs_pkg::S_RD_A: state_d = afs_pkg::S_EXEC;
			afs_pkg::S_EXEC: begin
				if (sts.mod_go) begin
					state_d = afs_pkg::S_MOD;
				end else if (sts.fix_go) begin
					state_d = afs_pkg::S_RD_B;
				end else begin
					state_d = afs_pkg::S_RD_C;
				end
			end
			afs_pkg::S_MOD: begin
				if (sts.mod_last) begin
					state_d = afs_pkg::S_RD_C;
				end
			end
			afs_pkg::S_RD_B: state_d = afs_pkg::S_FIX;
			afs_pkg::S_FIX:  state_d = afs_pkg::S_RD_C;
			afs_pkg::S_RD_C: state_d = afs_pkg::S_FIN;
			afs_pkg::S_FIN: begin
				if (fin_ok) begin
					state_d = afs_pkg::S_IDLE;
				end
			end
			default: state_d = afs_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		case (state_q)
			afs_pkg::S_IDLE: cmd.capture = in_valid;
			afs_pkg::S_RD_A: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = 1'b1;
			end
			afs_pkg::S_EXEC: cmd.exec     = 1'b1;
			afs_pkg::S_MOD:  cmd.mod_step = 1'b1;
			afs_pkg::S_RD_B: cmd.rd_en    = 1'b1;
			afs_pkg::S_FIX:  cmd.fix_last = 1'b1;
			afs_pkg::S_RD_C: cmd.rd_en    = 1'b1;
			afs_pkg::S_FIN:  cmd.fin_load = fin_ok;
			default: cmd = '0;
		endcase
	end

	// State register and result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= afs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/afs_dp.sv =====
// Datapath of the animation frame sequencer: play state, configuration registers,
// frame length table, bit-serial remainder unit and result register.
// Depends on afs_pkg and afs_ram.
`timescale 1ns / 1ps

module afs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  afs_pkg::cmd_t                      cmd,
	output afs_pkg::sts_t                      sts,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [afs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// command word
	input  logic [afs_pkg::OP_W-1:0]           op,
	input  logic [afs_pkg::SEL_W-1:0]          motion_sel,
	input  logic [afs_pkg::MODE_W-1:0]         mode_req,
	input  logic signed [afs_pkg::FREQ_W-1:0]  frame_req,
	input  logic [afs_pkg::FRAME_W-1:0]        length_in,
	// result word
	output logic [afs_pkg::FRAME_W-1:0]        frame_now,
	output logic [afs_pkg::SEL_W-1:0]          motion_now,
	output logic [afs_pkg::MODE_W-1:0]         mode_now,
	output logic                               accepted,
	output logic                               playing
);

	localparam int FW = afs_pkg::FRAME_W;

	// Play state and configuration
	logic [FW-1:0]                      frame_q;
	logic [afs_pkg::SEL_W-1:0]          cur_q, que_q;
	logic [afs_pkg::MODE_W-1:0]         mode_q;
	logic                               run_en_q;
	logic [afs_pkg::COUNT_W-1:0]        mcount_q;

	// Captured command word
	logic [afs_pkg::OP_W-1:0]           op_q;
	logic [afs_pkg::SEL_W-1:0]          sel_q;
	logic [afs_pkg::MODE_W-1:0]         mreq_q;
	logic signed [afs_pkg::FREQ_W-1:0]  freq_q;
	logic [FW-1:0]                      lin_q;
	logic                               acc_q;

	// Remainder unit
	logic [FW-1:0]                      rem_q, num_q, den_q;
	logic [afs_pkg::MCNT_W-1:0]         mcnt_q;
	logic [FW:0]                        rem_sh;
	logic [FW-1:0]                      rem_nx;

	// Table port
	logic                               tbl_we;
	logic [FW-1:0]                      tbl_wdata;
	logic [afs_pkg::SEL_W-1:0]          tbl_raddr;
	logic [FW-1:0]                      n;

	// Update terms
	logic [FW-1:0]                      last;
	logic [FW:0]                        f1;
	logic [FW-1:0]                      once_f, dec_f, div_num;
	logic                               tick_act, loop_mode, rev_sl_mode;
	logic                               chg_rej, play_ok;
	logic [afs_pkg::MODE_W-1:0]         mode_eff;
	logic [FW-1:0]                      stop_f;

	afs_ram #(
		.WIDTH (FW),
		.DEPTH (afs_pkg::MOTIONS)
	) u_len_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sel_q),
		.wdata (tbl_wdata),
		.re    (cmd.rd_en),
		.raddr (tbl_raddr),
		.rdata (n)
	);

	// Table addressing: a change looks up the named motion, all else the current one
	assign tbl_raddr = (cmd.rd_first && op_q == afs_pkg::OP_CHANGE) ? sel_q : cur_q;
	assign tbl_we    = cmd.exec && op_q == afs_pkg::OP_LOAD;
	assign tbl_wdata = (lin_q > afs_pkg::FRAME_MAX) ? afs_pkg::FRAME_MAX : lin_q;

	// Frame stepping
	assign last    = (n == '0) ? '0 : n - FW'(1);
	assign f1      = {1'b0, frame_q} + (FW+1)'(1);
	assign once_f  = (f1 < {1'b0, last}) ? f1[FW-1:0] : last;
	assign dec_f   = (frame_q == '0) ? '0 : frame_q - FW'(1);
	assign div_num = (mode_q == afs_pkg::MODE_LOOP) ? f1[FW-1:0] : frame_q + (n - FW'(1));

	assign tick_act    = op_q == afs_pkg::OP_TICK && run_en_q;
	assign loop_mode   = mode_q == afs_pkg::MODE_LOOP || mode_q == afs_pkg::MODE_REV_LOOP;
	assign rev_sl_mode = mode_q == afs_pkg::MODE_SL_REV_ONCE
		|| mode_q == afs_pkg::MODE_SL_REV_LOOP;

	assign sts.mod_go   = tick_act && loop_mode && n != '0;
	assign sts.fix_go   = tick_act && rev_sl_mode && dec_f == '0;
	assign sts.mod_last = mcnt_q == afs_pkg::MOD_LAST;

	// Change and play checks
	assign chg_rej  = mreq_q > afs_pkg::MODE_SL_REV_LOOP || {1'b0, sel_q} >= mcount_q;
	assign mode_eff = (cur_q == sel_q && mreq_q >= afs_pkg::MODE_SL_ONCE)
		? mreq_q - afs_pkg::MODE_SEAMLESS_OFS : mreq_q;
	assign play_ok  = freq_q >= afs_pkg::FREQ_KEEP && freq_q <= $signed({1'b0, n});

	// Saturate the stop frame
	always_comb begin
		if (freq_q < 0) begin
			stop_f = '0;
		end else if (freq_q > $signed({1'b0, afs_pkg::FRAME_MAX})) begin
			stop_f = afs_pkg::FRAME_MAX;
		end else begin
			stop_f = freq_q[FW-1:0];
		end
	end

	// Restoring remainder step
	assign rem_sh = {rem_q, num_q[FW-1]};
	assign rem_nx = (rem_sh >= {1'b0, den_q}) ? FW'(rem_sh - {1'b0, den_q}) : rem_sh[FW-1:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en_q <= 1'b0;
			mcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				afs_pkg::REG_RUN_ENABLE:   run_en_q <= cfg_data[0];
				afs_pkg::REG_MOTION_COUNT: mcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the command word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			sel_q  <= motion_sel;
			mreq_q <= mode_req;
			freq_q <= frame_req;
			lin_q  <= length_in;
		end
	end

	// Accepted flag
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			acc_q <= (op_q == afs_pkg::OP_CHANGE && !chg_rej)
				|| (op_q == afs_pkg::OP_PLAY && play_ok);
		end
	end

	// Remainder unit: load, then shift in one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.exec && sts.mod_go) begin
			rem_q  <= '0;
			num_q  <= div_num;
			den_q  <= n;
			mcnt_q <= '0;
		end else if (cmd.mod_step) begin
			rem_q  <= rem_nx;
			num_q  <= {num_q[FW-2:0], 1'b0};
			mcnt_q <= mcnt_q + afs_pkg::MCNT_W'(1);
		end
	end

	// Play state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			cur_q   <= '0;
			que_q   <= '0;
			mode_q  <= afs_pkg::MODE_ONCE;
		end else if (cmd.exec) begin
			case (afs_pkg::op_t'(op_q))
				afs_pkg::OP_TICK: begin
					if (run_en_q) begin
						case (mode_q)
							afs_pkg::MODE_ONCE:     frame_q <= once_f;
							afs_pkg::MODE_REV_ONCE: frame_q <= dec_f;
							afs_pkg::MODE_LOOP, afs_pkg::MODE_REV_LOOP: begin
								// nonzero length goes through the remainder unit
								if (n == '0) begin
									frame_q <= '0;
								end
							end
							afs_pkg::MODE_SL_ONCE, afs_pkg::MODE_SL_LOOP: begin
								if (once_f == last) begin
									cur_q   <= que_q;
									mode_q  <= mode_q - afs_pkg::MODE_SEAMLESS_OFS;
									frame_q <= '0;
								end else begin
									frame_q <= once_f;
								end
							end
							afs_pkg::MODE_SL_REV_ONCE, afs_pkg::MODE_SL_REV_LOOP: begin
								// on wrap the frame is set from the new motion's length
								if (dec_f == '0) begin
									cur_q  <= que_q;
									mode_q <= mode_q - afs_pkg::MODE_SEAMLESS_OFS;
								end else begin
									frame_q <= dec_f;
								end
							end
							default: ;
						endcase
					end
				end
				afs_pkg::OP_CHANGE: begin
					if (!chg_rej) begin
						mode_q <= mode_eff;
						case (mode_eff)
							afs_pkg::MODE_STOP: cur_q <= sel_q;
							afs_pkg::MODE_ONCE, afs_pkg::MODE_LOOP: begin
								cur_q   <= sel_q;
								frame_q <= '0;
							end
							afs_pkg::MODE_REV_ONCE, afs_pkg::MODE_REV_LOOP: begin
								cur_q   <= sel_q;
								frame_q <= last;
							end
							default: que_q <= sel_q;
						endcase
					end
				end
				afs_pkg::OP_PLAY: begin
					if (play_ok && freq_q != afs_pkg::FREQ_KEEP) begin
						frame_q <= freq_q[FW-1:0];
					end
				end
				afs_pkg::OP_STOP: begin
					if (freq_q != afs_pkg::FREQ_KEEP) begin
						frame_q <= stop_f;
					end
					mode_q <= afs_pkg::MODE_STOP;
				end
				default: ;
			endcase
		end else if (cmd.mod_step && sts.mod_last) begin
			frame_q <= rem_nx;
		end else if (cmd.fix_last) begin
			frame_q <= last;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			frame_now  <= frame_q;
			motion_now <= cur_q;
			mode_now   <= mode_q;
			accepted   <= acc_q;
			playing    <= frame_q != '0 && frame_q != n;
		end
	end

endmodule

// ===== hw/rtl/animation_frame_sequencer.sv =====
// Top level of the animation frame sequencer: joins controller and datapath
// to the channel interfaces. Depends on afs_pkg, afs_if, afs_ctrl and afs_dp.
//
//   channel  dir  flow          word
//   item     in   valid/ready   op, motion_sel, mode_req, frame_req, length_in
//   result   out  valid/ready   frame_now, motion_now, mode_now, accepted, playing
//   cfg      in   valid/ready   index, data (ready always high)
//
// One command word at a time, through read, update, read and result states; a
// tick in a loop mode adds the bit-serial remainder (one bit per cycle) and a tick
// ending a seamless reverse mode a read and a fix; a read state per lookup.
// The result register lets a new word in while the previous result waits.
// Reset clears play state and configuration; the length table is not cleared.
`timescale 1ns / 1ps

module animation_frame_sequencer (
	input  logic clk,
	input  logic arst_n,
	afs_item_if.sink     item,
	afs_result_if.source result,
	afs_cfg_if.sink      cfg
);

	afs_pkg::cmd_t cmd;
	afs_pkg::sts_t sts;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	afs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	afs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.op         (item.op),
		.motion_sel (item.motion_sel),
		.mode_req   (item.mode_req),
		.frame_req  (item.frame_req),
		.length_in  (item.length_in),
		.frame_now  (result.frame_now),
		.motion_now (result.motion_now),
		.mode_now   (result.mode_now),
		.accepted   (result.accepted),
		.playing    (result.playing)
	);

endmodule

// ===== bench/afs_checker.sv =====
// Checker for the animation frame sequencer: watches the command, result and
// configuration channels, predicts each status word and compares it on arrival.
// Depends on afs_pkg and afs_if.
`timescale 1ns / 1ps

module afs_checker (
	input  logic   clk,
	input  logic   arst_n,
	afs_item_if    item,
	afs_result_if  result,
	afs_cfg_if     cfg,
	output int     fail_count,
	output int     pending
);
	import afs_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [SEL_W-1:0]   motion;
		logic [MODE_W-1:0]  mode;
		logic               accepted;
		logic               playing;
	} status_word_t;

	// Shadow copy of the sequencer state and its registers
	logic [FRAME_W-1:0] frame_pos;
	logic [SEL_W-1:0]   cur_motion;
	logic [SEL_W-1:0]   queued_motion;
	logic [MODE_W-1:0]  play_mode;
	logic [FRAME_W-1:0] lengths [MOTIONS];
	logic               run_on;
	logic [COUNT_W-1:0] loaded_count;

	status_word_t expected_status [$];
	status_word_t want;
	status_word_t got;
	int           words_in;
	int           words_out;

	assign pending = words_in - words_out;

	function automatic logic [FRAME_W-1:0] last_frame(input logic [SEL_W-1:0] m);
		return (lengths[m] == '0) ? '0 : lengths[m] - 1'b1;
	endfunction

	// Advance the frame by one tick as the play mode directs
	function automatic void advance_frame();
		int n;
		int last;
		int f;
		n = lengths[cur_motion];
		last = last_frame(cur_motion);
		f = frame_pos;
		case (play_mode)
			MODE_ONCE: frame_pos = FRAME_W'((f + 1 < last) ? f + 1 : last);
			MODE_LOOP: frame_pos = FRAME_W'((n == 0) ? 0 : (f + 1) % n);
			MODE_REV_ONCE: frame_pos = FRAME_W'((f == 0) ? 0 : f - 1);
			MODE_REV_LOOP: frame_pos = FRAME_W'((n == 0) ? 0 : (f + n - 1) % n);
			MODE_SL_ONCE, MODE_SL_LOOP: begin
				f = (f + 1 < last) ? f + 1 : last;
				frame_pos = FRAME_W'(f);
				// end of the motion: hand over to the queued one
				if (f == last) begin
					cur_motion = queued_motion;
					play_mode = play_mode - MODE_SEAMLESS_OFS;
					frame_pos = '0;
				end
			end
			MODE_SL_REV_ONCE, MODE_SL_REV_LOOP: begin
				f = (f == 0) ? 0 : f - 1;
				frame_pos = FRAME_W'(f);
				if (f == 0) begin
					cur_motion = queued_motion;
					play_mode = play_mode - MODE_SEAMLESS_OFS;
					frame_pos = last_frame(cur_motion);
				end
			end
			default: ;
		endcase
	endfunction

	// Apply a motion change; return whether it was taken
	function automatic logic change_motion(input logic [SEL_W-1:0] sel,
		input logic [MODE_W-1:0] mode);
		int limit;
		logic [MODE_W-1:0] m;
		limit = (loaded_count < MOTIONS) ? int'(loaded_count) : MOTIONS;
		m = mode;
		if (m > MODE_SL_REV_LOOP || int'(sel) >= limit)
			return 1'b0;
		// a seamless request on the running motion degrades to the plain mode
		if (cur_motion == sel && m >= MODE_SL_ONCE)
			m = m - MODE_SEAMLESS_OFS;
		play_mode = m;
		if (m == MODE_STOP) begin
			cur_motion = sel;
		end else if (m <= MODE_LOOP) begin
			cur_motion = sel;
			frame_pos = '0;
		end else if (m <= MODE_REV_LOOP) begin
			cur_motion = sel;
			frame_pos = last_frame(sel);
		end else begin
			queued_motion = sel;
		end
		return 1'b1;
	endfunction

	// Run one command word through the shadow state and build its status word
	function automatic status_word_t execute_command(input logic [OP_W-1:0] op,
		input logic [SEL_W-1:0] sel, input logic [MODE_W-1:0] mode,
		input logic signed [FREQ_W-1:0] freq, input logic [FRAME_W-1:0] len);
		status_word_t w;
		int fq;
		int n;
		logic acc;
		acc = 1'b0;
		fq = freq;
		case (op)
			OP_TICK: begin
				if (run_on)
					advance_frame();
			end
			OP_CHANGE: acc = change_motion(sel, mode);
			OP_PLAY: begin
				n = lengths[cur_motion];
				if (fq >= -1 && fq <= n) begin
					acc = 1'b1;
					if (fq != -1)
						frame_pos = FRAME_W'(fq);
				end
			end
			OP_STOP: begin
				// saturate the stop frame into 0..MAX_FRAMES
				if (fq != -1) begin
					if (fq < 0)
						frame_pos = '0;
					else if (fq > MAX_FRAMES)
						frame_pos = FRAME_MAX;
					else
						frame_pos = FRAME_W'(fq);
				end
				play_mode = MODE_STOP;
			end
			OP_LOAD: lengths[sel] = (len > FRAME_MAX) ? FRAME_MAX : len;
			default: ;
		endcase
		w.frame = frame_pos;
		w.motion = cur_motion;
		w.mode = play_mode;
		w.accepted = acc;
		w.playing = (frame_pos != '0) && (frame_pos != lengths[cur_motion]);
		return w;
	endfunction

	// Track handshakes: compare results first, then predict the new word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = '0;
			cur_motion = '0;
			queued_motion = '0;
			play_mode = MODE_ONCE;
			run_on = 1'b0;
			loaded_count = '0;
			expected_status.delete();
			words_in <= 0;
			words_out <= 0;
			fail_count <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got.frame = result.frame_now;
				got.motion = result.motion_now;
				got.mode = result.mode_now;
				got.accepted = result.accepted;
				got.playing = result.playing;
				if (expected_status.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("[%0t] checker: result word with none expected", $time);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_status.pop_front();
					words_out <= words_out + 1;
					if (got !== want) begin
						if (fail_count < REPORT_LIMIT) begin
							$write("[%0t] checker: mismatch (expected/actual) frame %0d/%0d",
								$time, want.frame, got.frame);
							$display(" motion %0d/%0d mode %0d/%0d accepted %0b/%0b playing %0b/%0b",
								want.motion, got.motion, want.mode, got.mode,
								want.accepted, got.accepted, want.playing, got.playing);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (item.valid && item.ready) begin
				expected_status.push_back(execute_command(item.op, item.motion_sel,
					item.mode_req, item.frame_req, item.length_in));
				words_in <= words_in + 1;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_RUN_ENABLE:   run_on = cfg.data[0];
					REG_MOTION_COUNT: loaded_count = cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the animation frame sequencer bench: clock, reset, command and
// configuration stimulus, result-side back-pressure and the verdict.
// Depends on afs_pkg, afs_if, animation_frame_sequencer and afs_checker.
`timescale 1ns / 1ps

module testbench;
	import afs_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int IDLE_PCT        = 36;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int PHASES          = 6;
	localparam int PHASE_WORDS     = 155;

	// op codes the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet = 1'b0;
	bit   hold_request = 1'b0;
	int   cycle_count;
	int   hold_count;
	int   fail_count;
	int   pending;

	afs_item_if   item_ch ();
	afs_result_if result_ch ();
	afs_cfg_if    cfg_ch ();

	animation_frame_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	afs_checker sequencer_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if it never drains
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	// Result side: random stalls, a quiet stretch, and one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_OFF_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_request = 1'b0;
			end else if (quiet) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one command word, after a random gap, and hold it until taken
	task automatic send_word(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
		input logic [MODE_W-1:0] mode, input logic signed [FREQ_W-1:0] freq,
		input logic [FRAME_W-1:0] len);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.motion_sel <= sel;
		item_ch.mode_req <= mode;
		item_ch.frame_req <= freq;
		item_ch.length_in <= len;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid and wait until every predicted status word has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Random command word, weighted toward ticks and short motions
	task automatic send_random_word();
		int pick;
		logic [OP_W-1:0] op;
		logic [MODE_W-1:0] mode;
		logic signed [FREQ_W-1:0] freq;
		logic [FRAME_W-1:0] len;
		pick = $urandom_range(99);
		if (pick < 45)
			op = OP_TICK;
		else if (pick < 65)
			op = OP_CHANGE;
		else if (pick < 77)
			op = OP_PLAY;
		else if (pick < 84)
			op = OP_STOP;
		else if (pick < 96)
			op = OP_LOAD;
		else
			op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		if ($urandom_range(99) < 85)
			mode = MODE_W'($urandom_range(MODE_SL_REV_LOOP));
		else
			mode = MODE_W'($urandom_range(15, int'(MODE_SL_REV_LOOP) + 1));
		pick = $urandom_range(99);
		if (pick < 30)
			freq = FREQ_KEEP;
		else if (pick < 70)
			freq = FREQ_W'($urandom_range(12));
		else
			freq = FREQ_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)
			len = '0;
		else if (pick < 65)
			len = FRAME_W'($urandom_range(10, 1));
		else
			len = FRAME_W'($urandom_range(2047));
		send_word(op, SEL_W'($urandom_range(MOTIONS - 1)), mode, freq, len);
	endtask

	initial begin
		int phase_run [PHASES];
		int phase_count [PHASES];
		phase_run = '{1, 1, 0, 1, 1, 1};
		phase_count = '{16, 16, 0, 1, 7, 3};
		item_ch.valid <= 1'b0;
		item_ch.op <= OP_TICK;
		item_ch.motion_sel <= '0;
		item_ch.mode_req <= MODE_STOP;
		item_ch.frame_req <= FREQ_KEEP;
		item_ch.length_in <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_RUN_ENABLE;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_RUN_ENABLE, CFG_DATA_W'(1));
		write_reg(REG_MOTION_COUNT, CFG_DATA_W'(MOTIONS));

		// Load the motions used below, motion 0 first since status words read it until a change
		send_word(OP_LOAD, 4'd0, MODE_STOP, FREQ_KEEP, 11'd4);
		send_word(OP_LOAD, 4'd1, MODE_STOP, FREQ_KEEP, 11'd1);
		send_word(OP_LOAD, 4'd2, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_LOAD, 4'd3, MODE_STOP, FREQ_KEEP, 11'd2047);
		send_word(OP_LOAD, 4'd4, MODE_STOP, FREQ_KEEP, 11'd1024);

		// Play bounds: keep, end of motion, one past the end, below keep
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_PLAY, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_PLAY, 4'd0, MODE_STOP, 12'sd4, 11'd0);
		send_word(OP_PLAY, 4'd0, MODE_STOP, 12'sd5, 11'd0);
		send_word(OP_PLAY, 4'd0, MODE_STOP, -12'sd2, 11'd0);

		// Stop saturation both ways, stop keeping the frame, tick while stopped
		send_word(OP_STOP, 4'd0, MODE_STOP, 12'sh800, 11'd0);
		send_word(OP_STOP, 4'd0, MODE_STOP, 12'sh7FF, 11'd0);
		send_word(OP_STOP, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);

		// Loop over an empty motion, reverse once
		send_word(OP_CHANGE, 4'd2, MODE_LOOP, FREQ_KEEP, 11'd0);
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd0, MODE_REV_ONCE, FREQ_KEEP, 11'd0);
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);

		// Seamless hand-over forward, then the same-motion downgrade
		send_word(OP_CHANGE, 4'd1, MODE_ONCE, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd4, MODE_SL_LOOP, FREQ_KEEP, 11'd0);
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd4, MODE_SL_REV_ONCE, FREQ_KEEP, 11'd0);

		// Seamless hand-over in reverse
		send_word(OP_CHANGE, 4'd1, MODE_REV_LOOP, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd3, MODE_SL_REV_LOOP, FREQ_KEEP, 11'd0);
		send_word(OP_TICK, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);

		// Bad mode, plain stop by change, unused op codes
		send_word(OP_CHANGE, 4'd0, 4'd15, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);
		send_word(OP_SPARE_FIRST, 4'd15, 4'd15, 12'sh7FF, 11'd2047);
		send_word(OP_SPARE_LAST, 4'd0, MODE_STOP, FREQ_KEEP, 11'd0);

		// Index at and below the loaded count
		drain();
		write_reg(REG_MOTION_COUNT, 5'd2);
		send_word(OP_CHANGE, 4'd2, MODE_ONCE, FREQ_KEEP, 11'd0);
		send_word(OP_CHANGE, 4'd1, MODE_ONCE, FREQ_KEEP, 11'd0);

		// Fill the rest of the length table before anything random can read it
		drain();
		write_reg(REG_MOTION_COUNT, CFG_DATA_W'(MOTIONS));
		for (int m = 5; m < MOTIONS; m++)
			send_word(OP_LOAD, SEL_W'(m), MODE_STOP, FREQ_KEEP,
				FRAME_W'($urandom_range(12, 1)));

		// Random phases: first without idling, second with a long result hold-off
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == PHASES - 1)
				phase_count[p] = $urandom_range(15, 2);
			write_reg(REG_RUN_ENABLE, CFG_DATA_W'(phase_run[p]));
			write_reg(REG_MOTION_COUNT, CFG_DATA_W'(phase_count[p]));
			quiet = (p == 0);
			if (p == 1)
				hold_request = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++)
				send_random_word();
		end
		quiet = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/afs_pkg.sv
hw/rtl/afs_if.sv
hw/rtl/afs_ram.sv
hw/rtl/afs_ctrl.sv
hw/rtl/afs_dp.sv
hw/rtl/animation_frame_sequencer.sv
bench/afs_checker.sv
bench/testbench.sv
